@@ hdl/pps_pkg.sv @@
// shared types and codes for the preemptive priority scheduler
// no dependencies; imported by every module of the block but pps_check
package pps_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_HOLD
  } state_t;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  // one table entry as kept in the task memory
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

  // input payload, lowest field in the lowest bits
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] arrival;
  } in_data_t;

  // result payload, lowest field in the lowest bits
  typedef struct packed {
    logic        table_full;
    logic        all_done;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic [15:0] finish_time;
    logic        finished;
    logic [3:0]  task_index;
    logic        idle;
    logic [15:0] slot_time;
  } res_t;

endpackage

@@ hdl/preemptive_priority_scheduler_core.sv @@
// channel    | signals                          | payload
// input      | s_axis_tvalid/tready/tdata/tuser | tuser: kind; tdata: arrival, burst, prio
// result     | m_axis_tvalid/tready/tdata       | tdata: slot_time .. table_full (9 fields)
//
// load, clear and unused kinds: the transfer, then ST_HOLD, then the result register loads.
// a tick: one memory read per table entry in ST_SCAN, then the read pipeline drains,
// ST_UPDATE does the write-back, ST_HOLD loads the result; the scan sets the rate.
// one item is in flight at a time; the result register lets a finished item
// wait for m_axis_tready while the next item is taken.
// synchronous active-high rst empties the table and sets time to zero.
// top level: instantiates pps_ctrl and pps_mem, holds the result register
module preemptive_priority_scheduler_core
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // arrival[15:0], burst[31:16], prio[39:32]
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // slot_time, idle, task_index, finished, finish_time,
                                      // turnaround, waiting, all_done, table_full
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic             out_free;
  logic             push;
  res_t             res;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  pps_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (kind_t'(s_axis_tuser)),
    .in_data   (in_data_t'(s_axis_tdata)),
    .out_free  (out_free),
    .push      (push),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pps_mem #(
    .DEPTH (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_axis_tdata <= res;
    end
  end

endmodule

@@ hdl/pps_mem.sv @@
// task table memory: one write port, one read port, registered read data
// depends on pps_pkg for the entry layout
module pps_mem
  import pps_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/pps_ctrl.sv @@
// sequencer: load/clear handling, table scan for the best ready task,
// read-modify-write of the chosen entry and result assembly; uses pps_pkg
module pps_ctrl
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  kind_t            in_kind,
  input  in_data_t         in_data,
  input  logic             out_free,
  output logic             push,
  output res_t             res,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  entry_t           mem_rdata
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_TASKS);

  state_t           state, state_next;
  logic [CNT_W-1:0] task_count;
  logic [CNT_W-1:0] pending;
  logic [15:0]      now;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  entry_t           best;

  logic             accept;
  logic             issue;
  logic             load_go;
  logic             candidate;
  logic [15:0]      now_inc;
  logic [15:0]      rem_dec;
  logic             fin;
  logic [15:0]      ta;
  logic [15:0]      wt;
  logic [IDX_W+3:0] idx_wide;
  logic [CNT_W-1:0] pending_after;

  assign accept   = in_valid && in_ready;
  assign issue    = (state == ST_SCAN) && (scan_idx < task_count);
  assign load_go  = accept && (in_kind == KIND_LOAD) && (task_count < CAP);

  // entry beats the current best on strictly lower prio, so ties keep the lower index
  assign candidate = rd_vld && (mem_rdata.remaining != 16'd0) && (mem_rdata.arrival <= now)
                     && (!found || (mem_rdata.prio < best.prio));

  assign now_inc  = (now != TIME_MAX) ? now + 16'd1 : now;
  assign rem_dec  = best.remaining - 16'd1;
  assign fin      = found && (rem_dec == 16'd0);
  assign ta       = now_inc - best.arrival;
  assign wt       = (ta >= best.burst) ? ta - best.burst : 16'd0;
  assign idx_wide = {4'b0000, best_idx};
  assign pending_after = pending - CNT_W'(fin);

  // memory port drive
  always_comb begin
    mem_re    = issue;
    mem_raddr = scan_idx[IDX_W-1:0];
    mem_we    = load_go || ((state == ST_UPDATE) && found);
    if (load_go) begin
      mem_waddr = task_count[IDX_W-1:0];
      mem_wdata = '{arrival: in_data.arrival, burst: in_data.burst,
                    remaining: in_data.burst, prio: in_data.prio};
    end else begin
      mem_waddr = best_idx;
      mem_wdata = best;
      mem_wdata.remaining = rem_dec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_kind == KIND_TICK) ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (!issue && !rd_vld) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_HOLD;
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_HOLD: push = out_free;
      default: begin
        in_ready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      pending    <= '0;
      now        <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      scan_idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res           <= '0;
            res.slot_time <= now;
            res.all_done  <= (pending == '0);
            scan_idx      <= '0;
            found         <= 1'b0;
            rd_vld        <= 1'b0;
            case (in_kind)
              KIND_LOAD: begin
                if (task_count < CAP) begin
                  task_count <= task_count + CNT_W'(1);
                  if (in_data.burst != 16'd0) begin
                    pending      <= pending + CNT_W'(1);
                    res.all_done <= 1'b0;
                  end
                end else begin
                  res.table_full <= 1'b1;
                end
              end
              KIND_CLEAR: begin
                task_count   <= '0;
                pending      <= '0;
                now          <= '0;
                res.all_done <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          rd_vld <= issue;
          rd_idx <= scan_idx[IDX_W-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (candidate) begin
            found    <= 1'b1;
            best     <= mem_rdata;
            best_idx <= rd_idx;
          end
        end
        ST_UPDATE: begin
          now          <= now_inc;
          res.idle     <= !found;
          res.all_done <= (pending_after == '0);
          pending      <= pending_after;
          if (found) begin
            res.task_index <= idx_wide[3:0];
          end
          if (fin) begin
            res.finished    <= 1'b1;
            res.finish_time <= now_inc;
            res.turnaround  <= ta;
            res.waiting     <= wt;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/pps_check.sv @@
// port-level checks for preemptive_priority_scheduler_core, bound below
// depends only on the top level's ports
module pps_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // an idle slot never reports a finished task
  a_idle_fin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |-> !m_axis_tdata[21])
    else $error("idle slot with finished task");

  // a rejected load reports no tick fields
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[71] |-> !m_axis_tdata[16] && !m_axis_tdata[21])
    else $error("table full on a non-load result");

  // waiting never exceeds turnaround
  a_wait_le_ta: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[69:54] <= m_axis_tdata[53:38])
    else $error("waiting above turnaround");

endmodule

bind preemptive_priority_scheduler_core pps_check u_pps_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ test/preemptive_priority_scheduler_core_test.sv @@
// self-checking bench for preemptive_priority_scheduler_core: directed and random load/tick/clear
// streams, a calm closing run, results predicted per transfer and checked field by field
// depends on pps_pkg and the core only
module preemptive_priority_scheduler_core_test;
  import pps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH = 16;
  localparam int          STALL_LIMIT = 3000;
  localparam int          RANDOM_ITEMS = 970;
  localparam logic [1:0]  KIND_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    bit          sync;    // hold the sender until every report is back
    bit          quiet;   // from here on no idling on either side
  } sched_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  preemptive_priority_scheduler_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sched_item_t work_q[$];
  res_t        slot_reports_q[$];
  sched_item_t cur_item;
  int          mismatches = 0;
  int          reports_seen = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;

  // predicted task table
  logic [15:0] tab_arrival[TABLE_DEPTH];
  logic [15:0] tab_burst[TABLE_DEPTH];
  logic [15:0] tab_left[TABLE_DEPTH];
  logic [7:0]  tab_prio[TABLE_DEPTH];
  int          tab_used = 0;
  logic [15:0] cur_time = '0;

  function automatic res_t run_scheduler_item(sched_item_t it);
    res_t        r;
    bit          found;
    int          best;
    logic [15:0] span;
    r = '0;
    found = 1'b0;
    best = 0;
    r.slot_time = cur_time;
    if (it.kind == KIND_LOAD) begin
      if (tab_used < TABLE_DEPTH) begin
        tab_arrival[tab_used] = it.arrival;
        tab_burst[tab_used] = it.burst;
        tab_left[tab_used] = it.burst;
        tab_prio[tab_used] = it.prio;
        tab_used++;
      end else begin
        r.table_full = 1'b1;
      end
    end else if (it.kind == KIND_TICK) begin
      for (int i = 0; i < tab_used; i++) begin
        if (tab_left[i] != 0 && tab_arrival[i] <= cur_time) begin
          if (!found || tab_prio[i] < tab_prio[best]) begin
            best = i;
            found = 1'b1;
          end
        end
      end
      if (cur_time != TIME_MAX) cur_time = cur_time + 16'd1;
      if (!found) begin
        r.idle = 1'b1;
      end else begin
        r.task_index = best[3:0];
        tab_left[best] = tab_left[best] - 16'd1;
        if (tab_left[best] == 0) begin
          span = cur_time - tab_arrival[best];
          r.finished = 1'b1;
          r.finish_time = cur_time;
          r.turnaround = span;
          r.waiting = (span >= tab_burst[best]) ? span - tab_burst[best] : 16'd0;
        end
      end
    end else if (it.kind == KIND_CLEAR) begin
      tab_used = 0;
      cur_time = '0;
    end
    r.all_done = 1'b1;
    for (int i = 0; i < tab_used; i++) begin
      if (tab_left[i] != 0) r.all_done = 1'b0;
    end
    return r;
  endfunction

  task automatic add_item(logic [1:0] k, logic [15:0] a, logic [15:0] b, logic [7:0] p);
    sched_item_t it;
    it.kind = k;
    it.arrival = a;
    it.burst = b;
    it.prio = p;
    it.sync = 1'b0;
    it.quiet = 1'b0;
    work_q.push_back(it);
  endtask

  task automatic add_marker(bit s, bit q);
    sched_item_t it;
    it = '{kind: KIND_LOAD, arrival: '0, burst: '0, prio: '0, sync: s, quiet: q};
    work_q.push_back(it);
  endtask

  task automatic check_field(string fname, int unsigned want, int unsigned seen);
    if (want != seen) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
    end
  endtask

  // sender
  int tx_gap = 0;
  bit tx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) slot_reports_q.push_back(run_scheduler_item(cur_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (work_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (work_q[0].quiet) begin
          no_idle = 1'b1;
          work_q.delete(0);
          s_axis_tvalid <= 1'b0;
        end else if (work_q[0].sync) begin
          if (slot_reports_q.size() == 0) work_q.delete(0);
          s_axis_tvalid <= 1'b0;
        end else if (!no_idle && !tx_calm && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_item = work_q.pop_front();
          s_axis_tdata <= {cur_item.prio, cur_item.burst, cur_item.arrival};
          s_axis_tuser <= cur_item.kind;
          s_axis_tvalid <= 1'b1;
        end
      end
      if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
    end
  end

  // receiver and checker
  int rx_gap = 0;
  int rx_hold = 0;
  bit rx_calm = 1'b0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        got = res_t'(m_axis_tdata);
        if (slot_reports_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = slot_reports_q.pop_front();
          check_field("slot_time", want.slot_time, got.slot_time);
          check_field("idle", want.idle, got.idle);
          check_field("task_index", want.task_index, got.task_index);
          check_field("finished", want.finished, got.finished);
          check_field("finish_time", want.finish_time, got.finish_time);
          check_field("turnaround", want.turnaround, got.turnaround);
          check_field("waiting", want.waiting, got.waiting);
          check_field("all_done", want.all_done, got.all_done);
          check_field("table_full", want.table_full, got.table_full);
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (!held_once && reports_seen >= 200) begin
        // long back-pressure so the input side backs up
        held_once = 1'b1;
        rx_hold = 150;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && !rx_calm && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          n_rand;
    int          n_load;
    int          n_tick;
    int          work_sum;
    int          pick;
    logic [15:0] b;
    n_rand = 0;

    // directed: empty table, field extremes, zero burst, spare kind, ties, preemption
    add_item(KIND_TICK, 16'h0000, 16'h0001, 8'h00);
    add_item(KIND_LOAD, 16'h0000, 16'h0001, 8'hFF);
    add_item(KIND_LOAD, 16'hFFFF, 16'hFFFF, 8'h00);
    add_item(KIND_LOAD, 16'h0000, 16'h0000, 8'h00);
    add_item(KIND_SPARE, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_item(KIND_LOAD, 16'h0001, 16'h0002, 8'h08);
    add_item(KIND_LOAD, 16'h0001, 16'h0001, 8'h08);
    add_item(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
    add_item(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
    add_item(KIND_LOAD, 16'h0000, 16'h0001, 8'h01);
    repeat (5) add_item(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
    // fill the table and go one past it
    for (int k = 0; k < 11; k++) add_item(KIND_LOAD, 16'(k), 16'(k + 1), 8'(128 - k));
    add_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_item(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
    add_marker(1'b1, 1'b0);

    // random: mostly clear/load/tick runs, some raw noise
    while (n_rand < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          add_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom));
          n_rand++;
        end
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          add_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
          n_rand++;
        end
        n_load = $urandom_range(1, 16) + (($urandom_range(0, 7) == 0) ? 2 : 0);
        work_sum = 0;
        for (int k = 0; k < n_load; k++) begin
          pick = $urandom_range(0, 15);
          b = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 6));
          if (b <= 8) work_sum += b;
          add_item(KIND_LOAD, 16'($urandom_range(0, 12)), b,
                   8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255)));
          n_rand++;
        end
        n_tick = work_sum + $urandom_range(0, 8);
        if (n_tick > 100) n_tick = 100;
        for (int t = 0; t < n_tick; t++) begin
          // task arriving mid-run, often preempting the current one
          if ($urandom_range(0, 11) == 0) begin
            add_item(KIND_LOAD, 16'(t + $urandom_range(0, 3)), 16'($urandom_range(1, 4)),
                     8'($urandom_range(0, 3)));
            n_rand++;
          end
          add_item(KIND_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
          n_rand++;
        end
      end
    end

    // closing run with no idling: a later, more urgent arrival preempts
    add_marker(1'b0, 1'b1);
    add_item(KIND_CLEAR, 16'h0000, 16'h0000, 8'h00);
    add_item(KIND_LOAD, 16'd0, 16'd4, 8'd9);
    add_item(KIND_LOAD, 16'd2, 16'd3, 8'd5);
    add_item(KIND_LOAD, 16'd1, 16'd2, 8'd1);
    repeat (12) add_item(KIND_TICK, 16'h0000, 16'h0000, 8'h00);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (work_q.size() != 0 || s_axis_tvalid || slot_reports_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
